/* design/grot_pkg.sv */
// Shared types and constants of the grid ray occlusion test unit.
package grot_pkg;

  // Fixed field widths of the transaction payloads.
  localparam int COORD_W = 14;
  localparam int TILE_W  = 6;

  // Defaults of the top-level parameters.
  localparam int MAP_SIDE_DEF    = 64;
  localparam int FRAC_BITS_DEF   = 8;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Crossing-time numerators grow by one tile per step and stay below
  // the segment length plus two tiles.
  localparam int NUM_W  = COORD_W + 2;
  localparam int PROD_W = NUM_W + COORD_W;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_CAST  = 1'b1
  } act_e;

  // One classified item as it travels from the front end to the back end.
  typedef struct packed {
    act_e               action;
    logic [TILE_W-1:0]  tile_x;
    logic [TILE_W-1:0]  tile_y;
    logic               solid;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] ex;
    logic [COORD_W-1:0] ey;
    logic               x_neg;
    logic               y_neg;
    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
    logic [PROD_W-1:0]  px;
    logic [PROD_W-1:0]  py;
  } item_t;

endpackage

/* design/grot_in_if.sv */
// Input channel interface: valid/ready handshake with the request payload.
interface grot_in_if;
  import grot_pkg::*;

  logic               valid;
  logic               ready;
  logic               action;
  logic [TILE_W-1:0]  tile_x;
  logic [TILE_W-1:0]  tile_y;
  logic               solid;
  logic [COORD_W-1:0] from_x;
  logic [COORD_W-1:0] from_y;
  logic [COORD_W-1:0] to_x;
  logic [COORD_W-1:0] to_y;

  modport source (
    output valid, action, tile_x, tile_y, solid, from_x, from_y, to_x, to_y,
    input  ready
  );

  modport sink (
    input  valid, action, tile_x, tile_y, solid, from_x, from_y, to_x, to_y,
    output ready
  );
endinterface

/* design/grot_out_if.sv */
// Output channel interface: valid/ready handshake with the hit result.
interface grot_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (
    output valid, hit,
    input  ready
  );

  modport sink (
    input  valid, hit,
    output ready
  );
endinterface

/* design/grot_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module grot_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = grot_pkg::MAP_SIDE_DEF * grot_pkg::MAP_SIDE_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

/* design/grot_front.sv */
// Front end: accepts transactions, splits coordinates into cells and sets up crossing terms.
module grot_front #(
  parameter int FRAC_BITS = grot_pkg::FRAC_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  grot_in_if.sink         in_i,
  output grot_pkg::item_t push_data_o,
  output logic            push_valid_o,
  input  logic            push_ready_i
);
  import grot_pkg::*;

  localparam logic [COORD_W-1:0] FRAC_MASK = COORD_W'((1 << FRAC_BITS) - 1);
  localparam logic [NUM_W-1:0]   ONE       = NUM_W'(1 << FRAC_BITS);

  typedef struct packed {
    act_e               action;
    logic [TILE_W-1:0]  tile_x;
    logic [TILE_W-1:0]  tile_y;
    logic               solid;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] ex;
    logic [COORD_W-1:0] ey;
    logic               x_neg;
    logic               y_neg;
    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
    logic [NUM_W-1:0]   numx;
    logic [NUM_W-1:0]   numy;
  } setup_t;

  setup_t             stg_d, stg_q;
  logic               stg_valid_q;
  logic [COORD_W-1:0] frac_x, frac_y;

  assign in_i.ready = en_i && (!stg_valid_q || push_ready_i);

  assign frac_x = in_i.from_x & FRAC_MASK;
  assign frac_y = in_i.from_y & FRAC_MASK;

  // The distance to the first boundary is the fraction when moving down,
  // and one tile minus the fraction otherwise.
  always_comb begin
    stg_d.action = act_e'(in_i.action);
    stg_d.tile_x = in_i.tile_x;
    stg_d.tile_y = in_i.tile_y;
    stg_d.solid  = in_i.solid;
    stg_d.cx     = in_i.from_x >> FRAC_BITS;
    stg_d.cy     = in_i.from_y >> FRAC_BITS;
    stg_d.ex     = in_i.to_x >> FRAC_BITS;
    stg_d.ey     = in_i.to_y >> FRAC_BITS;
    stg_d.x_neg  = in_i.from_x > in_i.to_x;
    stg_d.y_neg  = in_i.from_y > in_i.to_y;
    stg_d.ax     = stg_d.x_neg ? in_i.from_x - in_i.to_x : in_i.to_x - in_i.from_x;
    stg_d.ay     = stg_d.y_neg ? in_i.from_y - in_i.to_y : in_i.to_y - in_i.from_y;
    stg_d.numx   = stg_d.x_neg ? NUM_W'(frac_x) : ONE - NUM_W'(frac_x);
    stg_d.numy   = stg_d.y_neg ? NUM_W'(frac_y) : ONE - NUM_W'(frac_y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      stg_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      stg_q <= stg_d;
    end
  end

  // Cross-multiplied crossing times: x goes first when numx*ay <= numy*ax.
  always_comb begin
    push_data_o.action = stg_q.action;
    push_data_o.tile_x = stg_q.tile_x;
    push_data_o.tile_y = stg_q.tile_y;
    push_data_o.solid  = stg_q.solid;
    push_data_o.cx     = stg_q.cx;
    push_data_o.cy     = stg_q.cy;
    push_data_o.ex     = stg_q.ex;
    push_data_o.ey     = stg_q.ey;
    push_data_o.x_neg  = stg_q.x_neg;
    push_data_o.y_neg  = stg_q.y_neg;
    push_data_o.ax     = stg_q.ax;
    push_data_o.ay     = stg_q.ay;
    push_data_o.px     = PROD_W'(stg_q.numx) * PROD_W'(stg_q.ay);
    push_data_o.py     = PROD_W'(stg_q.numy) * PROD_W'(stg_q.ax);
  end

  assign push_valid_o = stg_valid_q;
endmodule

/* design/grot_queue.sv */
// Short register queue that decouples the front end from the back end.
module grot_queue #(
  parameter int DEPTH = grot_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  grot_pkg::item_t push_data_i,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  output grot_pkg::item_t pop_data_o,
  output logic            pop_valid_o,
  input  logic            pop_i
);
  import grot_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push, pop;

  assign push_ready_o = count_q != CNT_W'(DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end
endmodule

/* design/grot_back.sv */
// Back end: owns the solid map, clears it after reset, performs writes and walks casts.
module grot_back #(
  parameter int MAP_SIDE  = grot_pkg::MAP_SIDE_DEF,
  parameter int FRAC_BITS = grot_pkg::FRAC_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  output logic            map_ready_o,
  input  grot_pkg::item_t pop_data_i,
  input  logic            pop_valid_i,
  output logic            pop_o,
  grot_out_if.source      out_o
);
  import grot_pkg::*;

  localparam int CELL_W = COORD_W - FRAC_BITS;
  localparam int MAP_W  = $clog2(MAP_SIDE);
  localparam int ADDR_W = 2 * MAP_W;
  localparam int EXT_A  = (CELL_W > TILE_W) ? CELL_W : TILE_W;
  localparam int EXT_W  = (EXT_A > MAP_W + 1) ? EXT_A : MAP_W + 1;
  localparam logic [EXT_W-1:0]  SIDE      = EXT_W'(MAP_SIDE);
  localparam logic [ADDR_W-1:0] ADDR_LAST = '1;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_LAST  = 4'b1000
  } state_e;

  state_e             state_d, state_q;
  logic [ADDR_W-1:0]  clr_addr_d, clr_addr_q;
  logic               chk_d, chk_q;
  logic               out_valid_d, out_valid_q;
  logic               hit_d, hit_q;
  logic [CELL_W-1:0]  cx_d, cx_q, cy_d, cy_q, ex_d, ex_q, ey_d, ey_q;
  logic               x_neg_d, x_neg_q, y_neg_d, y_neg_q;
  logic [COORD_W-1:0] ax_d, ax_q, ay_d, ay_q;
  logic [PROD_W-1:0]  px_d, px_q, py_d, py_q;
  logic [PROD_W-1:0]  dpx, dpy;
  logic               x_first, out_free;
  logic [EXT_W-1:0]   rd_x, rd_y, wr_x, wr_y;
  logic               rd_in_map, wr_in_map;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic               ram_we, ram_wdata, ram_rdata;
  logic [ADDR_W-1:0]  ram_waddr;

  assign rd_x      = EXT_W'(cx_q);
  assign rd_y      = EXT_W'(cy_q);
  assign wr_x      = EXT_W'(pop_data_i.tile_x);
  assign wr_y      = EXT_W'(pop_data_i.tile_y);
  assign rd_in_map = (rd_x < SIDE) && (rd_y < SIDE);
  assign wr_in_map = (wr_x < SIDE) && (wr_y < SIDE);
  assign rd_addr   = {rd_y[MAP_W-1:0], rd_x[MAP_W-1:0]};
  assign wr_addr   = {wr_y[MAP_W-1:0], wr_x[MAP_W-1:0]};

  // Each step on an axis adds one tile to that axis's numerator.
  assign dpx     = PROD_W'(ay_q) << FRAC_BITS;
  assign dpy     = PROD_W'(ax_q) << FRAC_BITS;
  assign x_first = px_q <= py_q;

  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    chk_d       = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;
    hit_d       = hit_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    ex_d        = ex_q;
    ey_d        = ey_q;
    x_neg_d     = x_neg_q;
    y_neg_d     = y_neg_q;
    ax_d        = ax_q;
    ay_d        = ay_q;
    px_d        = px_q;
    py_d        = py_q;
    ram_we      = 1'b0;
    ram_waddr   = clr_addr_q;
    ram_wdata   = 1'b0;
    pop_o       = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        ram_we     = 1'b1;
        clr_addr_d = clr_addr_q + ADDR_W'(1);
        if (clr_addr_q == ADDR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop_valid_i && out_free) begin
          pop_o = 1'b1;
          if (pop_data_i.action == ACT_WRITE) begin
            ram_we      = wr_in_map;
            ram_waddr   = wr_addr;
            ram_wdata   = pop_data_i.solid;
            out_valid_d = 1'b1;
            hit_d       = 1'b0;
          end else begin
            cx_d    = pop_data_i.cx[CELL_W-1:0];
            cy_d    = pop_data_i.cy[CELL_W-1:0];
            ex_d    = pop_data_i.ex[CELL_W-1:0];
            ey_d    = pop_data_i.ey[CELL_W-1:0];
            x_neg_d = pop_data_i.x_neg;
            y_neg_d = pop_data_i.y_neg;
            ax_d    = pop_data_i.ax;
            ay_d    = pop_data_i.ay;
            px_d    = pop_data_i.px;
            py_d    = pop_data_i.py;
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        // The current cell is read now; its data is checked next cycle.
        chk_d = rd_in_map;
        if (chk_q && ram_rdata) begin
          out_valid_d = 1'b1;
          hit_d       = 1'b1;
          state_d     = ST_IDLE;
        end else if (x_first) begin
          if (cx_q == ex_q) begin
            state_d = ST_LAST;
          end else begin
            px_d = px_q + dpx;
            cx_d = x_neg_q ? cx_q - CELL_W'(1) : cx_q + CELL_W'(1);
          end
        end else begin
          if (cy_q == ey_q) begin
            state_d = ST_LAST;
          end else begin
            py_d = py_q + dpy;
            cy_d = y_neg_q ? cy_q - CELL_W'(1) : cy_q + CELL_W'(1);
          end
        end
      end
      ST_LAST: begin
        out_valid_d = 1'b1;
        hit_d       = chk_q && ram_rdata;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      chk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      chk_q       <= chk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q   <= hit_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    ex_q    <= ex_d;
    ey_q    <= ey_d;
    x_neg_q <= x_neg_d;
    y_neg_q <= y_neg_d;
    ax_q    <= ax_d;
    ay_q    <= ay_d;
    px_q    <= px_d;
    py_q    <= py_d;
  end

  grot_ram #(
    .WIDTH (1),
    .DEPTH (1 << ADDR_W)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  assign map_ready_o = state_q != ST_CLEAR;
  assign out_o.valid = out_valid_q;
  assign out_o.hit   = hit_q;

  // A cast never writes the map while it walks.
  a_no_write_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK || state_q == ST_LAST) |-> !ram_we)
    else $error("map written during a cast walk");

  // A cast only starts with the output register free, so it is empty while walking.
  a_out_empty_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK || state_q == ST_LAST) |-> !out_valid_q)
    else $error("result register occupied during a cast walk");

  // Nothing leaves the queue before the clearing pass is over.
  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == ST_IDLE && pop_valid_i))
    else $error("queue popped outside the idle state");

  // Leaving the clearing pass happens only after the last map address.
  a_clear_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(state_q) == ST_CLEAR && state_q == ST_IDLE) |-> clr_addr_q == '0)
    else $error("clearing pass ended early");
endmodule

/* design/grid_ray_occlusion_test_unit.sv */
// Top level of the grid ray occlusion test unit: front end, queue and back end.
// Each accepted transaction passes the front stage register and the queue; a tile write
// then sets the result register, while a cast first walks its cells, ending early on a solid cell.
// The back end finishes one transaction before it pops the next, with one map read per
// visited cell of a cast.
// Reset: asynchronous, active low; afterwards the map is cleared one tile per cycle over every
// address of the map RAM while in_i.ready stays low.
module grid_ray_occlusion_test_unit #(
  parameter int MAP_SIDE    = grot_pkg::MAP_SIDE_DEF,
  parameter int FRAC_BITS   = grot_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = grot_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  grot_in_if.sink    in_i,
  grot_out_if.source out_o
);
  import grot_pkg::*;

  // The front end registers each accepted transaction and precomputes the start and end
  // cells, the step directions, the absolute deltas and the cross-multiplied crossing
  // times of the first cell boundaries. The multiplications sit between the front end's
  // stage register and the queue, so the back end only adds and compares.
  item_t front_data;
  logic  front_valid;
  logic  front_ready;

  // Classified items waiting for the back end. While a long cast walks, further
  // transactions are still taken until the queue and the front stage are full.
  item_t queue_data;
  logic  queue_valid;
  logic  queue_pop;

  // Low during the clearing pass that follows reset.
  logic map_ready;

  grot_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (map_ready),
    .in_i         (in_i),
    .push_data_o  (front_data),
    .push_valid_o (front_valid),
    .push_ready_i (front_ready)
  );

  grot_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_data),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_data_o   (queue_data),
    .pop_valid_o  (queue_valid),
    .pop_i        (queue_pop)
  );

  // The back end owns the solid map. A write updates one tile and returns a zero result
  // at once. A cast steps through the cells in DDA order, one cell per cycle: the cell's
  // map bit is read in the cycle it is visited and checked in the next, and the first
  // solid cell ends the walk. The output register holds the result until it is taken,
  // while the front end keeps accepting transactions until the queue and its stage are full.
  grot_back #(
    .MAP_SIDE  (MAP_SIDE),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .map_ready_o (map_ready),
    .pop_data_i  (queue_data),
    .pop_valid_i (queue_valid),
    .pop_o       (queue_pop),
    .out_o       (out_o)
  );
endmodule

/* test/grot_sightline_checker.sv */
// Checker for the grid ray occlusion test unit: tracks the tile map and scores every hit result.
`timescale 1ns / 1ps

module grot_sightline_checker #(
  parameter int MAP_SIDE  = grot_pkg::MAP_SIDE_DEF,
  parameter int FRAC_BITS = grot_pkg::FRAC_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  grot_in_if   in_mon_i,
  grot_out_if  out_mon_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   writes_o,
  output int   casts_o,
  output int   blocked_o
);
  import grot_pkg::*;

  bit solid_tiles [MAP_SIDE][MAP_SIDE];
  bit hit_due [$];
  int fails;
  int results_seen;
  int n_writes;
  int n_casts;
  int n_blocked;

  // Walks the cells of one segment in grid order; crossing times are compared
  // by cross-multiplication, and a tie or two empty axes step in x.
  function automatic bit trace_blocked(input longint unsigned fx, input longint unsigned fy,
                                       input longint unsigned tx, input longint unsigned ty);
    longint unsigned one_tile;
    longint unsigned ax;
    longint unsigned ay;
    longint unsigned nx;
    longint unsigned ny;
    int cx;
    int cy;
    int ex;
    int ey;
    int sx;
    int sy;
    bit x_step;
    one_tile = 64'd1 << FRAC_BITS;
    cx = int'(fx >> FRAC_BITS);
    cy = int'(fy >> FRAC_BITS);
    ex = int'(tx >> FRAC_BITS);
    ey = int'(ty >> FRAC_BITS);
    sx = (tx > fx) ? 1 : ((tx < fx) ? -1 : 0);
    sy = (ty > fy) ? 1 : ((ty < fy) ? -1 : 0);
    ax = (tx > fx) ? tx - fx : fx - tx;
    ay = (ty > fy) ? ty - fy : fy - ty;
    nx = (fx > tx) ? (fx & (one_tile - 1)) : one_tile - (fx & (one_tile - 1));
    ny = (fy > ty) ? (fy & (one_tile - 1)) : one_tile - (fy & (one_tile - 1));
    while (1'b1) begin
      if (cx < MAP_SIDE && cy < MAP_SIDE && solid_tiles[cy][cx]) begin
        return 1'b1;
      end
      if (ax == 0) begin
        x_step = (ay == 0);
      end else if (ay == 0) begin
        x_step = 1'b1;
      end else begin
        x_step = (nx * ay <= ny * ax);
      end
      if (x_step) begin
        if (cx == ex) begin
          return 1'b0;
        end
        nx += one_tile;
        cx += sx;
      end else begin
        if (cy == ey) begin
          return 1'b0;
        end
        ny += one_tile;
        cy += sy;
      end
    end
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bit want;
    bit blocked;
    if (!rst_ni) begin
      foreach (solid_tiles[y, x]) begin
        solid_tiles[y][x] = 1'b0;
      end
      hit_due.delete();
      fails        = 0;
      results_seen = 0;
      n_writes     = 0;
      n_casts      = 0;
      n_blocked    = 0;
    end else begin
      // Results leave in order, so the older expectation is scored before a new one is queued.
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (hit_due.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none, got hit=%0b",
                   $time, out_mon_i.hit);
          fails++;
        end else begin
          want = hit_due.pop_front();
          if (out_mon_i.hit !== want) begin
            $display("%0t: result %0d hit mismatch, expected %0b, got %0b",
                     $time, results_seen, want, out_mon_i.hit);
            fails++;
          end
        end
        results_seen++;
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        if (act_e'(in_mon_i.action) == ACT_WRITE) begin
          if (in_mon_i.tile_x < MAP_SIDE && in_mon_i.tile_y < MAP_SIDE) begin
            solid_tiles[in_mon_i.tile_y][in_mon_i.tile_x] = in_mon_i.solid;
          end
          hit_due.insert(hit_due.size(), 1'b0);
          n_writes++;
        end else begin
          blocked = trace_blocked(64'(in_mon_i.from_x), 64'(in_mon_i.from_y),
                                  64'(in_mon_i.to_x), 64'(in_mon_i.to_y));
          hit_due.insert(hit_due.size(), blocked);
          n_casts++;
          if (blocked) begin
            n_blocked++;
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= hit_due.size();
    writes_o     <= n_writes;
    casts_o      <= n_casts;
    blocked_o    <= n_blocked;
  end

endmodule

/* test/tb_grid_ray_occlusion_test_unit.sv */
// Testbench top of the grid ray occlusion test unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_grid_ray_occlusion_test_unit;
  import grot_pkg::*;

  localparam int MAP_SIDE   = MAP_SIDE_DEF;
  localparam int FRAC_BITS  = FRAC_BITS_DEF;
  localparam int COORD_MAX  = (1 << COORD_W) - 1;
  localparam int RAND_ITEMS = 750;
  // Tiles in this square get most of the writes, so short casts through it meet walls.
  localparam int HOT_LO     = 16;
  localparam int HOT_HI     = 39;
  // Even with ready low through the map clear after reset, a correct run never
  // goes anywhere near this many cycles without a transaction on either side.
  localparam int IDLE_LIMIT = 20000;
  // The longest cast visits about two cells per map side.
  localparam int DRAIN_CYCLES = 2 * MAP_SIDE + 8;

  logic clk;
  logic rst_n;
  bit   quiet;
  int   ready_hold;
  int   idle_cycles;
  int   fail_count;
  int   pending;
  int   n_writes;
  int   n_casts;
  int   n_blocked;

  grot_in_if  in_if ();
  grot_out_if out_if ();

  grid_ray_occlusion_test_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  grot_sightline_checker #(
    .MAP_SIDE  (MAP_SIDE),
    .FRAC_BITS (FRAC_BITS)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_mon_i     (in_if),
    .out_mon_i    (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .writes_o     (n_writes),
    .casts_o      (n_casts),
    .blocked_o    (n_blocked)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Idle length for either side. Most gaps are short, a few are long, and during a quiet
  // stretch there are none, so back-to-back transactions get exercised as well.
  function automatic int idle_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (quiet || r < 60) begin
      return 0;
    end else if (r < 90) begin
      return int'($urandom_range(1, 3));
    end else if (r < 98) begin
      return int'($urandom_range(4, 12));
    end
    return int'($urandom_range(20, 60));
  endfunction

  function automatic logic [COORD_W-1:0] clamp_coord(input int v);
    if (v < 0) begin
      return '0;
    end else if (v > COORD_MAX) begin
      return COORD_W'(COORD_MAX);
    end
    return COORD_W'(v);
  endfunction

  // Presents one transaction after a random gap and holds it until the unit takes it.
  // A gap of zero leaves valid high, so consecutive transactions follow without a bubble.
  task automatic put_item(input act_e act, input logic [TILE_W-1:0] tx,
                          input logic [TILE_W-1:0] ty,
                          input logic s, input logic [COORD_W-1:0] fx,
                          input logic [COORD_W-1:0] fy, input logic [COORD_W-1:0] ex,
                          input logic [COORD_W-1:0] ey);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.action <= act;
    in_if.tile_x <= tx;
    in_if.tile_y <= ty;
    in_if.solid  <= s;
    in_if.from_x <= fx;
    in_if.from_y <= fy;
    in_if.to_x   <= ex;
    in_if.to_y   <= ey;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // The fields a write does not use carry random values, which the unit must ignore.
  task automatic put_write(input logic [TILE_W-1:0] x, input logic [TILE_W-1:0] y,
                           input logic s);
    put_item(ACT_WRITE, x, y, s, COORD_W'($urandom()), COORD_W'($urandom()),
             COORD_W'($urandom()), COORD_W'($urandom()));
  endtask

  task automatic put_cast(input int fx, input int fy, input int ex, input int ey);
    put_item(ACT_CAST, TILE_W'($urandom()), TILE_W'($urandom()), 1'($urandom()),
             clamp_coord(fx), clamp_coord(fy), clamp_coord(ex), clamp_coord(ey));
  endtask

  // The result side stalls at random; ready is high for at least one cycle between stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (ready_hold > 0) begin
      out_if.ready <= 1'b0;
      ready_hold   <= ready_hold - 1;
    end else begin
      out_if.ready <= 1'b1;
      ready_hold   <= idle_gap();
    end
  end

  // Watchdog: a long run of cycles with no transaction on either channel means a hang.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, IDLE_LIMIT, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int item;
    int kind;
    int fx;
    int fy;
    int ex;
    int ey;
    int d;
    int fr;
    int sub;

    quiet        = 1'b0;
    rst_n        = 1'b0;
    in_if.valid  <= 1'b0;
    in_if.action <= ACT_WRITE;
    in_if.tile_x <= '0;
    in_if.tile_y <= '0;
    in_if.solid  <= 1'b0;
    in_if.from_x <= '0;
    in_if.from_y <= '0;
    in_if.to_x   <= '0;
    in_if.to_y   <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A zero-length cast on the empty map tests only the start cell.
    put_cast(0, 0, 0, 0);
    put_write(0, 0, 1'b1);
    put_cast(0, 0, 0, 0);
    // Corner tiles and the full diagonal at the coordinate extremes.
    put_write(63, 63, 1'b1);
    put_cast(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    put_cast(0, 0, COORD_MAX, COORD_MAX);
    put_write(0, 0, 1'b0);
    put_cast(COORD_MAX, COORD_MAX, 0, 0);
    put_cast(0, COORD_MAX, COORD_MAX, 0);
    put_write(63, 63, 1'b0);
    // A ray through exact cell corners: ties step in x, so the tile above the corner is
    // seen and the one to its left is not.
    put_write(1, 0, 1'b1);
    put_cast(128, 128, 640, 640);
    put_write(1, 0, 1'b0);
    put_write(0, 1, 1'b1);
    put_cast(128, 128, 640, 640);
    // Ending on a cell boundary, and walking backwards onto a corner.
    put_cast(256, 256, 128, 128);
    put_cast(128, 128, 256, 256);
    put_write(0, 1, 1'b0);
    // A vertical ray has no x crossings at all, a horizontal one no y crossings.
    put_write(5, 40, 1'b1);
    put_cast(5 * 256 + 10, 0, 5 * 256 + 10, COORD_MAX);
    put_cast(0, 40 * 256 + 200, COORD_MAX, 40 * 256 + 200);
    put_cast(COORD_MAX, 40 * 256, 6 * 256, 40 * 256);
    put_write(5, 40, 1'b0);
    put_cast(5 * 256 + 10, 0, 5 * 256 + 10, COORD_MAX);

    // Random part: writes go mostly into the hot square so that short casts find walls,
    // while long casts over the whole map and exact diagonals and axis rays are mixed in.
    for (item = 0; item < RAND_ITEMS; item++) begin
      quiet = (item >= 300 && item < 400);
      kind  = int'($urandom_range(0, 99));
      if (kind < 30) begin
        if ($urandom_range(0, 9) < 6) begin
          put_write(TILE_W'($urandom_range(HOT_LO, HOT_HI)),
                    TILE_W'($urandom_range(HOT_LO, HOT_HI)), $urandom_range(0, 99) < 55);
        end else begin
          put_write(TILE_W'($urandom()), TILE_W'($urandom()), $urandom_range(0, 99) < 55);
        end
      end else if (kind < 58) begin
        fx = int'($urandom_range(0, COORD_MAX));
        fy = int'($urandom_range(0, COORD_MAX));
        ex = fx + int'($urandom_range(0, 1536)) - 768;
        ey = fy + int'($urandom_range(0, 1536)) - 768;
        put_cast(fx, fy, ex, ey);
      end else if (kind < 80) begin
        put_cast(int'($urandom_range(HOT_LO * 256, HOT_HI * 256 + 255)),
                 int'($urandom_range(HOT_LO * 256, HOT_HI * 256 + 255)),
                 int'($urandom_range(HOT_LO * 256, HOT_HI * 256 + 255)),
                 int'($urandom_range(HOT_LO * 256, HOT_HI * 256 + 255)));
      end else if (kind < 90) begin
        put_cast(int'($urandom_range(0, COORD_MAX)), int'($urandom_range(0, COORD_MAX)),
                 int'($urandom_range(0, COORD_MAX)), int'($urandom_range(0, COORD_MAX)));
      end else begin
        sub = int'($urandom_range(0, 2));
        fx  = int'($urandom_range(0, COORD_MAX));
        fy  = int'($urandom_range(0, COORD_MAX));
        if (sub == 0) begin
          // Equal steps and fractions on both axes tie every crossing if both move the same way.
          fr = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 255));
          fx = int'($urandom_range(8, 55)) * 256 + fr;
          fy = int'($urandom_range(8, 55)) * 256 + fr;
          d  = int'($urandom_range(0, 2047));
          ex = $urandom_range(0, 1) ? fx + d : fx - d;
          ey = $urandom_range(0, 1) ? fy + d : fy - d;
          put_cast(fx, fy, ex, ey);
        end else if (sub == 1) begin
          put_cast(fx, fy, int'($urandom_range(0, COORD_MAX)), fy);
        end else begin
          put_cast(fx, fy, fx, int'($urandom_range(0, COORD_MAX)));
        end
      end
    end
    in_if.valid <= 1'b0;
    quiet = 1'b0;

    // The checker must count the last transaction before the wait for the drain starts.
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d tile writes and %0d casts, of which %0d were blocked.",
             n_writes, n_casts, n_blocked);
    $display("Mismatches found: %0d", fail_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
